// ----- hdl/isort_pkg.sv -----
// Shared widths, defaults and cell control type for the insertion sorter.
`default_nettype none

package isort_pkg;

  localparam int ValueWidth  = 32;
  localparam int CapacityDef = 64;

  typedef logic signed [ValueWidth-1:0] isort_value_t;

  // Broadcast from the control to every cell in the chain.
  typedef struct packed {
    logic         insert;
    logic         shift;
    isort_value_t value;
  } isort_cell_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/isort_if.sv -----
// Valid/ready channel interfaces for the insertion sorter input and result streams.
`default_nettype none

interface isort_in_if
  import isort_pkg::*;
();
  logic         valid;
  logic         ready;
  isort_value_t value;
  logic         end_of_set;

  modport source (output valid, output value, output end_of_set, input ready);
  modport sink   (input valid, input value, input end_of_set, output ready);
endinterface

interface isort_out_if
  import isort_pkg::*;
();
  logic         valid;
  logic         ready;
  isort_value_t sorted_value;
  logic         final_res;
  logic         overflowed;

  modport source (output valid, output sorted_value, output final_res,
                  output overflowed, input ready);
  modport sink   (input valid, input sorted_value, input final_res,
                  input overflowed, output ready);
endinterface

`default_nettype wire

// ----- hdl/isort_cell.sv -----
// One cell of the insertion chain: holds one list entry, compares and shifts.
`default_nettype none

module isort_cell
  import isort_pkg::*;
(
  input  wire                   clk_i,
  input  wire isort_cell_ctrl_t ctrl_i,
  input  wire                   occupied_i,
  input  wire                   at_end_i,
  input  wire                   lower_gt_i,
  input  wire isort_value_t     lower_value_i,
  input  wire isort_value_t     upper_value_i,
  output logic                  gt_o,
  output isort_value_t          value_o
);

  isort_value_t value_q, value_d;

  // Strictly greater keeps equal values in arrival order.
  assign gt_o    = occupied_i && (value_q > ctrl_i.value);
  assign value_o = value_q;

  always_comb begin
    value_d = value_q;
    if (ctrl_i.insert) begin
      if (lower_gt_i) begin
        value_d = lower_value_i;
      end else if (gt_o || at_end_i) begin
        value_d = ctrl_i.value;
      end
    end else if (ctrl_i.shift) begin
      value_d = upper_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

`default_nettype wire

// ----- hdl/insertion_sorter_top.sv -----
// Top level of the insertion sorter: cell chain plus fill and drain control.
`default_nettype none

// Insertion sorter. Values arrive one request per cycle while no drain runs
// and are inserted at once into a chain of CAPACITY cells, each comparing
// against the broadcast value and shifting its entry up one place when the
// entry is larger. The request flagged end_of_set starts the drain: the list
// leaves cell 0 in ascending order, one result per cycle while the sink is
// ready, by shifting the chain down. During the drain of N results (N up to
// CAPACITY) no input is taken; after the final result the block is empty
// again. Values that arrive with the chain full are dropped and every result
// of that set carries overflowed = 1.
module insertion_sorter_top
  import isort_pkg::*;
#(
  parameter int CAPACITY = CapacityDef
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  isort_in_if.sink     in_i,
  isort_out_if.source  out_o
);

  localparam int CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0]  count_q, count_d;
  logic             drain_q, drain_d;
  logic             flag_q, flag_d;
  isort_cell_ctrl_t ctrl;
  logic             in_acc, out_acc, full;

  logic         gt  [CAPACITY];
  isort_value_t val [CAPACITY];

  assign full    = (count_q == CntW'(CAPACITY));
  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;

  assign in_i.ready         = !drain_q;
  assign out_o.valid        = drain_q;
  assign out_o.sorted_value = val[0];
  assign out_o.final_res    = (count_q == CntW'(1));
  assign out_o.overflowed   = flag_q;

  assign ctrl.insert = in_acc && !full;
  assign ctrl.shift  = out_acc;
  assign ctrl.value  = in_i.value;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    isort_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occupied_i   (count_q > CntW'(i)),
      .at_end_i     (count_q == CntW'(i)),
      .lower_gt_i   ((i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i - 1]),
      .lower_value_i(val[(i == 0) ? 0 : i - 1]),
      .upper_value_i(val[(i == CAPACITY - 1) ? i : i + 1]),
      .gt_o         (gt[i]),
      .value_o      (val[i])
    );
  end

  always_comb begin
    count_d = count_q;
    drain_d = drain_q;
    flag_d  = flag_q;
    if (in_acc) begin
      if (full) begin
        flag_d = 1'b1;
      end else begin
        count_d = count_q + CntW'(1);
      end
      if (in_i.end_of_set) begin
        drain_d = 1'b1;
      end
    end
    if (out_acc) begin
      count_d = count_q - CntW'(1);
      // Last result taken: clear for the next set.
      if (count_q == CntW'(1)) begin
        drain_d = 1'b0;
        flag_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      drain_q <= 1'b0;
      flag_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      drain_q <= drain_d;
      flag_q  <= flag_d;
    end
  end

  a_drain_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_q |-> (count_q != '0))
    else $error("drain with empty chain");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_final_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_o.final_res) |=> (count_q == '0 && !drain_q && !flag_q))
    else $error("chain not cleared after final result");

  a_no_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input taken during drain");

endmodule

`default_nettype wire
